FILE: design/fsa_pkg.sv
// Shared types and codes for the fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package fsa_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_FIT_MODE   = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  // Fit modes
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // One free segment: header address and usable size
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } seg_entry_t;

endpackage
`default_nettype wire

FILE: design/fsa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module fsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: design/fit_segment_allocator_top.sv
// Top level of the fit segment allocator: sequencer, free table and totals.
`timescale 1ns / 1ps
`default_nettype none
// Heap allocator over an address space growing from zero. Free segments sit
// address-sorted in a RAM of TABLE_DEPTH entries; one item is handled at a time
// and in_stall stays high until its result is staged. The free-table scan reads
// one entry at a time through the single RAM read port, in a read state followed
// by an evaluate state, and inserting or removing an entry moves every later
// entry one slot, again with a read state and a write state for each entry.
// Configuration writes are always accepted (cfg_ready is high) and must only be
// made while the block is idle.
module fit_segment_allocator_top #(
  parameter int TABLE_DEPTH  = 64,
  parameter int HEADER_BYTES = 40,
  parameter int ADDR_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [31:0] in_req_size,
  input  wire logic [31:0] in_block_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_data_addr,
  output logic [31:0]      out_granted_size,
  output logic [31:0]      out_heap_total,
  output logic [31:0]      out_free_total,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import fsa_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] HB = 32'(HEADER_BYTES);
  localparam logic [33:0] SLACK = 34'(2 * HEADER_BYTES);
  localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << ADDR_BITS) - 64'd1);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_EV     = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHD_RD = 4'd4;
  localparam logic [3:0] S_SHD_WR = 4'd5;
  localparam logic [3:0] S_SHU_RD = 4'd6;
  localparam logic [3:0] S_SHU_WR = 4'd7;
  localparam logic [3:0] S_INS    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]    state_r;
  logic [CW-1:0] count_r, idx_r, pos_r;
  logic [31:0]   brk_r, free_r, limit_r;
  logic          fit_mode_r;
  logic          op_r;
  logic [31:0]   sz_r, hdr_r;
  logic          found_r, has_prev_r, has_cur_r;
  seg_entry_t    bst_r, prev_r, cur_r;
  logic [1:0]    res_status_r;
  logic [31:0]   res_data_r, res_granted_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_data_r, out_granted_r, out_heap_r, out_free_r;

  seg_entry_t    rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  seg_entry_t    wr_data;

  // Derived values for the decision step
  logic [CW-1:0] pos_m1, pos_p1, idx_p1, idx_m1;
  logic [31:0]   prev_end, rel_end, rem_start, rem_size;
  logic          mp, mn, full, take_whole, fits, better, stop;
  logic [33:0]   grow_nb;

  assign pos_m1 = pos_r - CW'(1);
  assign pos_p1 = pos_r + CW'(1);
  assign idx_p1 = idx_r + CW'(1);
  assign idx_m1 = idx_r - CW'(1);

  assign prev_end   = (prev_r.start + HB + prev_r.size) & AMASK;
  assign rel_end    = (hdr_r + HB + sz_r) & AMASK;
  assign mp         = has_prev_r && (prev_end == hdr_r);
  assign mn         = has_cur_r && (rel_end == cur_r.start);
  assign full       = (count_r >= CW'(TABLE_DEPTH));
  assign rem_start  = (bst_r.start + HB + sz_r) & AMASK;
  assign rem_size   = bst_r.size - sz_r - HB;
  assign take_whole = ({2'b0, bst_r.size} <= ({2'b0, sz_r} + SLACK));
  assign grow_nb    = {2'b0, brk_r} + {2'b0, HB} + {2'b0, sz_r};

  // Scan step evaluation for allocate
  assign fits   = (rd_data.size >= sz_r);
  assign better = fits && ((fit_mode_r == FIT_FIRST) || !found_r ||
                           (rd_data.size < bst_r.size));
  assign stop   = fits && ((fit_mode_r == FIT_FIRST) || (rd_data.size == sz_r));

  fsa_ram #(
    .WIDTH($bits(seg_entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(idx_r[IW-1:0]),
    .rd_data(rd_data)
  );

  // Table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r[IW-1:0];
    wr_data = rd_data;
    case (state_r)
      S_DECIDE: begin
        if (op_r == OP_ALLOC) begin
          if (found_r && !take_whole) begin
            wr_en         = 1'b1;
            wr_data.start = rem_start;
            wr_data.size  = rem_size;
          end
        end else if (mp) begin
          wr_en         = 1'b1;
          wr_addr       = pos_m1[IW-1:0];
          wr_data.start = prev_r.start;
          wr_data.size  = mn ? (prev_r.size + HB + sz_r + HB + cur_r.size)
                             : (prev_r.size + HB + sz_r);
        end else if (mn) begin
          wr_en         = 1'b1;
          wr_data.start = hdr_r;
          wr_data.size  = sz_r + HB + cur_r.size;
        end
      end
      S_SHD_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[IW-1:0];
      end
      S_SHU_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_p1[IW-1:0];
      end
      S_INS: begin
        wr_en         = 1'b1;
        wr_data.start = hdr_r;
        wr_data.size  = sz_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
      limit_r    <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIT_MODE:   fit_mode_r <= cfg_wdata[0];
        CFG_HEAP_LIMIT: limit_r    <= cfg_wdata;
        default:        fit_mode_r <= fit_mode_r;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      brk_r       <= '0;
      free_r      <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      has_prev_r  <= 1'b0;
      has_cur_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Result register empties on a transfer unless a new result is loaded
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= in_op;
            sz_r       <= in_req_size;
            hdr_r      <= (in_block_addr - HB) & AMASK;
            idx_r      <= '0;
            pos_r      <= '0;
            found_r    <= 1'b0;
            has_prev_r <= 1'b0;
            has_cur_r  <= 1'b0;
            state_r    <= (count_r == '0) ? S_DECIDE : S_RD;
          end
        end
        S_RD: begin
          state_r <= S_EV;
        end
        S_EV: begin
          if (op_r == OP_ALLOC) begin
            if (better) begin
              bst_r   <= rd_data;
              pos_r   <= idx_r;
              found_r <= 1'b1;
            end
            if (stop || idx_p1 == count_r) begin
              state_r <= S_DECIDE;
            end else begin
              idx_r   <= idx_p1;
              state_r <= S_RD;
            end
          end else if (rd_data.start >= hdr_r) begin
            cur_r     <= rd_data;
            has_cur_r <= 1'b1;
            pos_r     <= idx_r;
            state_r   <= S_DECIDE;
          end else begin
            prev_r     <= rd_data;
            has_prev_r <= 1'b1;
            pos_r      <= idx_p1;
            idx_r      <= idx_p1;
            state_r    <= (idx_p1 == count_r) ? S_DECIDE : S_RD;
          end
        end
        S_DECIDE: begin
          res_status_r  <= ST_OK;
          res_data_r    <= '0;
          res_granted_r <= '0;
          state_r       <= S_FIN;
          if (op_r == OP_ALLOC) begin
            if (found_r) begin
              res_data_r <= (bst_r.start + HB) & AMASK;
              if (take_whole) begin
                res_granted_r <= bst_r.size;
                free_r        <= free_r - HB - bst_r.size;
                if (pos_p1 < count_r) begin
                  idx_r   <= pos_p1;
                  state_r <= S_SHD_RD;
                end else begin
                  count_r <= count_r - CW'(1);
                end
              end else begin
                res_granted_r <= sz_r;
                free_r        <= free_r - HB - sz_r;
              end
            end else if (grow_nb <= {2'b0, limit_r} && grow_nb <= {2'b0, AMASK}) begin
              res_data_r    <= (brk_r + HB) & AMASK;
              res_granted_r <= sz_r;
              brk_r         <= grow_nb[31:0];
            end else begin
              res_status_r <= ST_NO_SPACE;
            end
          end else if (mp && mn) begin
            free_r <= free_r + HB + sz_r;
            if (pos_p1 < count_r) begin
              idx_r   <= pos_p1;
              state_r <= S_SHD_RD;
            end else begin
              count_r <= count_r - CW'(1);
            end
          end else if (mp || mn) begin
            free_r <= free_r + HB + sz_r;
          end else if (full) begin
            res_status_r <= ST_FULL;
          end else begin
            free_r <= free_r + HB + sz_r;
            if (pos_r < count_r) begin
              idx_r   <= count_r - CW'(1);
              state_r <= S_SHU_RD;
            end else begin
              state_r <= S_INS;
            end
          end
        end
        // Remove: move later entries down one slot
        S_SHD_RD: begin
          state_r <= S_SHD_WR;
        end
        S_SHD_WR: begin
          if (idx_p1 == count_r) begin
            count_r <= count_r - CW'(1);
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_p1;
            state_r <= S_SHD_RD;
          end
        end
        // Insert: move entries from the top down to pos up one slot
        S_SHU_RD: begin
          state_r <= S_SHU_WR;
        end
        S_SHU_WR: begin
          if (idx_r == pos_r) begin
            state_r <= S_INS;
          end else begin
            idx_r   <= idx_m1;
            state_r <= S_SHU_RD;
          end
        end
        S_INS: begin
          count_r <= count_r + CW'(1);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_data_r    <= res_data_r;
            out_granted_r <= res_granted_r;
            out_heap_r    <= brk_r;
            out_free_r    <= free_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data_addr    = out_data_r;
  assign out_granted_size = out_granted_r;
  assign out_heap_total   = out_heap_r;
  assign out_free_total   = out_free_r;

  // Table fill never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("free table count beyond depth");

  // An accepted item keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("sequencer idle right after accept");

  // The break only grows
  a_break_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (brk_r >= $past(brk_r)))
    else $error("heap break moved down");

  // Failed results grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_data_r == '0 && out_granted_r == '0))
    else $error("failed result carries a grant");

endmodule
`default_nettype wire
